@@ hdl/ptp_pkg.sv @@
// Package for the playback transport position block.
// Widths, command and state codes, register indexes and arithmetic sizing.
// Used by every other file of the block.
`default_nettype none

package ptp_pkg;

   localparam int POSITION_BITS      = 40;
   localparam int BEAT_FRACTION_BITS = 16;
   localparam int BEAT_BITS          = 60;
   localparam int TEMPO_W            = 18;
   localparam int RATE_W             = 20;
   localparam int BLOCK_W            = 16;
   localparam int SAMPLE_IN_W        = 41;
   localparam int BEAT_IN_W          = 61;
   localparam int CMD_W              = 3;
   localparam int STATE_W            = 2;
   localparam int CSR_INDEX_W        = 1;
   localparam int CSR_DATA_W         = 20;

   localparam logic [TEMPO_W-1:0] TEMPO_MIN   = 18'd5120;
   localparam logic [TEMPO_W-1:0] TEMPO_MAX   = 18'd255744;
   localparam logic [TEMPO_W-1:0] TEMPO_RESET = 18'd30720;
   localparam logic [RATE_W-1:0]  RATE_RESET  = 20'd48000;

   // rate * 60 * 256 = rate * 15360 = rate * 2^14 - rate * 2^10
   localparam int RATE_SCALED_W = RATE_W + 14;
   localparam int ACC_HI_W      = RATE_SCALED_W + 1;
   localparam int PROD_W        = ACC_HI_W + BEAT_BITS;
   localparam int DEN_W         = (TEMPO_W + BEAT_FRACTION_BITS + 1 > RATE_SCALED_W) ?
                                  TEMPO_W + BEAT_FRACTION_BITS + 1 : RATE_SCALED_W;
   localparam int REM_W         = DEN_W + 1;
   localparam int MUL_STEPS     = BEAT_BITS;
   localparam int DIV_STEPS     = PROD_W;
   localparam int MUL_CNT_W     = $clog2(MUL_STEPS);
   localparam int DIV_CNT_W     = $clog2(DIV_STEPS);
   localparam int SAMPLE_CMP_W  = (POSITION_BITS > SAMPLE_IN_W) ? POSITION_BITS : SAMPLE_IN_W;

   localparam logic [POSITION_BITS-1:0] SAMPLE_TOP = {POSITION_BITS{1'b1}};
   localparam logic [BEAT_BITS-1:0]     BEAT_TOP   = {BEAT_BITS{1'b1}};

   localparam logic [CMD_W-1:0] CMD_PLAY        = 3'd0;
   localparam logic [CMD_W-1:0] CMD_STOP        = 3'd1;
   localparam logic [CMD_W-1:0] CMD_PAUSE       = 3'd2;
   localparam logic [CMD_W-1:0] CMD_ADVANCE     = 3'd3;
   localparam logic [CMD_W-1:0] CMD_SET_SAMPLES = 3'd4;
   localparam logic [CMD_W-1:0] CMD_SET_BEATS   = 3'd5;

   localparam logic [STATE_W-1:0] RUN_STOPPED = 2'd0;
   localparam logic [STATE_W-1:0] RUN_PLAYING = 2'd1;
   localparam logic [STATE_W-1:0] RUN_PAUSED  = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_TEMPO = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_RATE  = 1'd1;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_START = 5'b00010,
      ST_MUL   = 5'b00100,
      ST_DIV   = 5'b01000,
      ST_DONE  = 5'b10000
   } seq_state_type;

   // divider result handed back to the sequencer
   typedef struct packed {
      logic                 done;
      logic                 overflow;
      logic [BEAT_BITS-1:0] quotient;
   } div_status_type;

endpackage

`default_nettype wire

@@ hdl/ptp_if.sv @@
// Handshake channels of the playback transport position block:
// command items, result items and register writes. Uses ptp_pkg.
`default_nettype none

interface ptp_req_if;
   logic                                     valid;
   logic                                     ready;
   logic [ptp_pkg::CMD_W-1:0]                cmd;
   logic [ptp_pkg::BLOCK_W-1:0]              block_length;
   logic signed [ptp_pkg::SAMPLE_IN_W-1:0]   new_sample_position;
   logic signed [ptp_pkg::BEAT_IN_W-1:0]     new_beat_position;

   modport source (output valid, cmd, block_length, new_sample_position, new_beat_position,
                   input ready);
   modport sink (input valid, cmd, block_length, new_sample_position, new_beat_position,
                 output ready);
endinterface

interface ptp_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [ptp_pkg::STATE_W-1:0]        run_state;
   logic [ptp_pkg::POSITION_BITS-1:0]  position_samples;
   logic [ptp_pkg::BEAT_BITS-1:0]      position_beats;

   modport source (output valid, run_state, position_samples, position_beats, input ready);
   modport sink (input valid, run_state, position_samples, position_beats, output ready);
endinterface

interface ptp_csr_if;
   logic                              valid;
   logic                              ready;
   logic [ptp_pkg::CSR_INDEX_W-1:0]   index;
   logic [ptp_pkg::CSR_DATA_W-1:0]    data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ hdl/playback_transport_position.sv @@
// Top level of the playback transport position block: run state, positions,
// registers, sequencer and result register. Uses ptp_pkg, ptp_if, ptp_mul, ptp_div.
//
//   channel  direction  fields                                             handshake
//   req      in         cmd, block_length, new_sample_position,
//                       new_beat_position                                  valid/ready
//   rsp      out        run_state, position_samples, position_beats        valid/ready
//   csr      in         index (0 tempo_q8, 1 rate in Hz), data             valid/ready
//
// Play, stop, pause, ignored codes and advance while not playing go from ST_IDLE straight
// to ST_DONE. Commands that move a position pass ST_START, ST_MUL for the bit-serial
// multiply, ST_DIV for the bit-serial divide, one bit per cycle, and ST_DONE for the result.
// One item at a time; the next item is taken while the last result waits on rsp.
// A stalled rsp holds the finished item before it is written to the result register.
// Reset is synchronous: stopped, positions zero, tempo 120 BPM, rate 48000.
`default_nettype none

module playback_transport_position (
   input  wire logic  clock,
   input  wire logic  reset,
   ptp_req_if.sink    req,
   ptp_rsp_if.source  rsp,
   ptp_csr_if.sink    csr
);

   ptp_pkg::seq_state_type               state_ff, state_in;
   logic [ptp_pkg::STATE_W-1:0]          run_ff, run_in;
   logic [ptp_pkg::POSITION_BITS-1:0]    sample_ff, sample_in;
   logic [ptp_pkg::BEAT_BITS-1:0]        beat_ff, beat_in;
   logic                                 to_beats_ff, to_beats_in;
   logic [ptp_pkg::TEMPO_W-1:0]          tempo_ff;
   logic [ptp_pkg::RATE_W-1:0]           rate_ff;
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic [ptp_pkg::STATE_W-1:0]          rsp_run_ff;
   logic [ptp_pkg::POSITION_BITS-1:0]    rsp_sample_ff;
   logic [ptp_pkg::BEAT_BITS-1:0]        rsp_beat_ff;

   logic                                 accept;
   logic                                 rsp_load;
   logic [ptp_pkg::RATE_SCALED_W-1:0]    rate_scaled;
   logic [ptp_pkg::POSITION_BITS:0]      adv_sum;
   logic [ptp_pkg::SAMPLE_CMP_W-1:0]     set_ext;
   logic [ptp_pkg::TEMPO_W-1:0]          tempo_wr;

   logic                                 mul_start;
   logic [ptp_pkg::BEAT_BITS-1:0]        mul_x;
   logic [ptp_pkg::RATE_SCALED_W-1:0]    mul_m;
   logic [ptp_pkg::ACC_HI_W-1:0]         mul_preset;
   logic                                 mul_done;
   logic [ptp_pkg::PROD_W-1:0]           mul_prod;
   logic [ptp_pkg::PROD_W-1:0]           div_num;
   logic [ptp_pkg::DEN_W-1:0]            div_den;
   ptp_pkg::div_status_type              div_status;

   assign accept      = req.valid && req.ready;
   assign req.ready   = state_ff == ptp_pkg::ST_IDLE;
   assign csr.ready   = 1'b1;
   assign rate_scaled = {rate_ff, 14'b0} - ptp_pkg::RATE_SCALED_W'({rate_ff, 10'b0});
   assign adv_sum     = {1'b0, sample_ff} + (ptp_pkg::POSITION_BITS + 1)'(req.block_length);
   assign set_ext     = ptp_pkg::SAMPLE_CMP_W'(unsigned'(req.new_sample_position));
   assign tempo_wr    = csr.data[ptp_pkg::TEMPO_W-1:0];

   // samples to beats: (samples * tempo) << frac / (rate * 15360)
   // beats to samples: (beats * rate * 15360 + tempo << (frac-1)) << 1 / (tempo << (frac+1))
   always_comb begin
      if (to_beats_ff) begin
         mul_x      = ptp_pkg::BEAT_BITS'(sample_ff);
         mul_m      = ptp_pkg::RATE_SCALED_W'(tempo_ff);
         mul_preset = '0;
         div_num    = mul_prod << ptp_pkg::BEAT_FRACTION_BITS;
         div_den    = ptp_pkg::DEN_W'(rate_scaled);
      end else begin
         mul_x      = beat_ff;
         mul_m      = rate_scaled;
         mul_preset = ptp_pkg::ACC_HI_W'(tempo_ff) << (ptp_pkg::BEAT_FRACTION_BITS - 1);
         div_num    = mul_prod << 1;
         div_den    = ptp_pkg::DEN_W'(tempo_ff) << (ptp_pkg::BEAT_FRACTION_BITS + 1);
      end
   end

   assign mul_start = state_ff == ptp_pkg::ST_START;
   assign rsp_load  = (state_ff == ptp_pkg::ST_DONE) && (!rsp_valid_ff || rsp.ready);

   always_comb begin
      state_in    = state_ff;
      run_in      = run_ff;
      sample_in   = sample_ff;
      beat_in     = beat_ff;
      to_beats_in = to_beats_ff;
      case (state_ff)
         ptp_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = ptp_pkg::ST_DONE;
               case (req.cmd)
                  ptp_pkg::CMD_PLAY: begin
                     run_in = ptp_pkg::RUN_PLAYING;
                  end
                  ptp_pkg::CMD_STOP: begin
                     run_in    = ptp_pkg::RUN_STOPPED;
                     sample_in = '0;
                     beat_in   = '0;
                  end
                  ptp_pkg::CMD_PAUSE: begin
                     run_in = ptp_pkg::RUN_PAUSED;
                  end
                  ptp_pkg::CMD_ADVANCE: begin
                     if (run_ff == ptp_pkg::RUN_PLAYING) begin
                        sample_in   = adv_sum[ptp_pkg::POSITION_BITS] ? ptp_pkg::SAMPLE_TOP
                                      : adv_sum[ptp_pkg::POSITION_BITS-1:0];
                        to_beats_in = 1'b1;
                        state_in    = ptp_pkg::ST_START;
                     end
                  end
                  ptp_pkg::CMD_SET_SAMPLES: begin
                     if (req.new_sample_position[ptp_pkg::SAMPLE_IN_W-1]) begin
                        sample_in = '0;
                     end else if (set_ext > ptp_pkg::SAMPLE_CMP_W'(ptp_pkg::SAMPLE_TOP)) begin
                        sample_in = ptp_pkg::SAMPLE_TOP;
                     end else begin
                        sample_in = set_ext[ptp_pkg::POSITION_BITS-1:0];
                     end
                     to_beats_in = 1'b1;
                     state_in    = ptp_pkg::ST_START;
                  end
                  ptp_pkg::CMD_SET_BEATS: begin
                     beat_in = req.new_beat_position[ptp_pkg::BEAT_IN_W-1] ? '0
                               : req.new_beat_position[ptp_pkg::BEAT_BITS-1:0];
                     to_beats_in = 1'b0;
                     state_in    = ptp_pkg::ST_START;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ptp_pkg::ST_START: begin
            state_in = ptp_pkg::ST_MUL;
         end
         ptp_pkg::ST_MUL: begin
            if (mul_done) begin
               state_in = ptp_pkg::ST_DIV;
            end
         end
         ptp_pkg::ST_DIV: begin
            if (div_status.done) begin
               state_in = ptp_pkg::ST_DONE;
               if (to_beats_ff) begin
                  beat_in = div_status.overflow ? ptp_pkg::BEAT_TOP : div_status.quotient;
               end else if (div_status.overflow
                            || (div_status.quotient >> ptp_pkg::POSITION_BITS) != '0) begin
                  sample_in = ptp_pkg::SAMPLE_TOP;
               end else begin
                  sample_in = div_status.quotient[ptp_pkg::POSITION_BITS-1:0];
               end
            end
         end
         ptp_pkg::ST_DONE: begin
            if (rsp_load) begin
               state_in = ptp_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ptp_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ptp_pkg::ST_IDLE;
         run_ff       <= ptp_pkg::RUN_STOPPED;
         sample_ff    <= '0;
         beat_ff      <= '0;
         to_beats_ff  <= 1'b0;
         tempo_ff     <= ptp_pkg::TEMPO_RESET;
         rate_ff      <= ptp_pkg::RATE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         run_ff       <= run_in;
         sample_ff    <= sample_in;
         beat_ff      <= beat_in;
         to_beats_ff  <= to_beats_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr.valid && csr.ready) begin
            case (csr.index)
               ptp_pkg::CSR_TEMPO: begin
                  if (tempo_wr < ptp_pkg::TEMPO_MIN) begin
                     tempo_ff <= ptp_pkg::TEMPO_MIN;
                  end else if (tempo_wr > ptp_pkg::TEMPO_MAX) begin
                     tempo_ff <= ptp_pkg::TEMPO_MAX;
                  end else begin
                     tempo_ff <= tempo_wr;
                  end
               end
               ptp_pkg::CSR_RATE: begin
                  rate_ff <= (csr.data == '0) ? ptp_pkg::RATE_W'(1) : csr.data;
               end
               default: begin
               end
            endcase
         end
      end
      if (rsp_load) begin
         rsp_run_ff    <= run_ff;
         rsp_sample_ff <= sample_ff;
         rsp_beat_ff   <= beat_ff;
      end
   end

   assign rsp.valid            = rsp_valid_ff;
   assign rsp.run_state        = rsp_run_ff;
   assign rsp.position_samples = rsp_sample_ff;
   assign rsp.position_beats   = rsp_beat_ff;

   ptp_mul u_mul (
      .clock  (clock),
      .reset  (reset),
      .start  (mul_start),
      .x      (mul_x),
      .m      (mul_m),
      .preset (mul_preset),
      .done   (mul_done),
      .prod   (mul_prod)
   );

   ptp_div u_div (
      .clock  (clock),
      .reset  (reset),
      .start  (mul_done),
      .num    (div_num),
      .den    (div_den),
      .status (div_status)
   );

endmodule

`default_nettype wire

@@ hdl/ptp_mul.sv @@
// Bit-serial shift-add multiplier: prod = x * m + preset, one multiplier bit a cycle.
// Uses ptp_pkg for widths.
`default_nettype none

module ptp_mul (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   input  wire logic [ptp_pkg::BEAT_BITS-1:0]       x,
   input  wire logic [ptp_pkg::RATE_SCALED_W-1:0]   m,
   input  wire logic [ptp_pkg::ACC_HI_W-1:0]        preset,
   output logic                                     done,
   output logic [ptp_pkg::PROD_W-1:0]               prod
);

   logic [ptp_pkg::PROD_W-1:0]        prod_ff, prod_in;
   logic [ptp_pkg::RATE_SCALED_W-1:0] m_ff;
   logic [ptp_pkg::MUL_CNT_W-1:0]     count_ff, count_in;
   logic                              busy_ff, busy_in;
   logic                              done_ff, done_in;
   logic [ptp_pkg::ACC_HI_W:0]        sum;

   // preset sits at the top half and ends up added at weight one after all shifts
   always_comb begin
      sum = {1'b0, prod_ff[ptp_pkg::PROD_W-1 -: ptp_pkg::ACC_HI_W]}
            + (prod_ff[0] ? (ptp_pkg::ACC_HI_W + 1)'(m_ff) : '0);
      prod_in  = prod_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         prod_in  = {preset, x};
         count_in = '0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         prod_in  = {sum, prod_ff[ptp_pkg::BEAT_BITS-1:1]};
         count_in = count_ff + 1'b1;
         if (count_ff == ptp_pkg::MUL_CNT_W'(ptp_pkg::MUL_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      prod_ff <= prod_in;
      if (start) begin
         m_ff <= m;
      end
   end

   assign done = done_ff;
   assign prod = prod_ff;

endmodule

`default_nettype wire

@@ hdl/ptp_div.sv @@
// Bit-serial restoring divider, one quotient bit a cycle, with a sticky
// overflow flag for quotients beyond the beat width. Uses ptp_pkg.
`default_nettype none

module ptp_div (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   input  wire logic [ptp_pkg::PROD_W-1:0]      num,
   input  wire logic [ptp_pkg::DEN_W-1:0]       den,
   output ptp_pkg::div_status_type              status
);

   logic [ptp_pkg::PROD_W-1:0]    num_ff, num_in;
   logic [ptp_pkg::DEN_W-1:0]     den_ff;
   logic [ptp_pkg::REM_W-1:0]     rem_ff, rem_in;
   logic [ptp_pkg::BEAT_BITS-1:0] quot_ff, quot_in;
   logic                          ovf_ff, ovf_in;
   logic [ptp_pkg::DIV_CNT_W-1:0] count_ff, count_in;
   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [ptp_pkg::REM_W-1:0]     rem_sh;
   logic                          fits;

   always_comb begin
      // remainder stays below den, so its top bit is always clear before the shift
      rem_sh   = {rem_ff[ptp_pkg::REM_W-2:0], num_ff[ptp_pkg::PROD_W-1]};
      fits     = rem_sh >= {1'b0, den_ff};
      num_in   = num_ff;
      rem_in   = rem_ff;
      quot_in  = quot_ff;
      ovf_in   = ovf_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         num_in   = num;
         rem_in   = '0;
         quot_in  = '0;
         ovf_in   = 1'b0;
         count_in = '0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         num_in   = {num_ff[ptp_pkg::PROD_W-2:0], 1'b0};
         rem_in   = fits ? rem_sh - {1'b0, den_ff} : rem_sh;
         quot_in  = {quot_ff[ptp_pkg::BEAT_BITS-2:0], fits};
         ovf_in   = ovf_ff | quot_ff[ptp_pkg::BEAT_BITS-1];
         count_in = count_ff + 1'b1;
         if (count_ff == ptp_pkg::DIV_CNT_W'(ptp_pkg::DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      num_ff  <= num_in;
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
      ovf_ff  <= ovf_in;
      if (start) begin
         den_ff <= den;
      end
   end

   assign status.done     = done_ff;
   assign status.overflow = ovf_ff;
   assign status.quotient = quot_ff;

endmodule

`default_nettype wire
